FILE: hdl/f64eu_pkg.sv
// Package for the float64 exponent unit: payload structs, constants, stage records.
// No dependencies.
package f64eu_pkg;

  localparam int FracBits = 52;
  localparam logic [10:0] ExpMax = 11'h7FF;
  localparam logic [10:0] HalfBiased = 11'd1022;

  typedef enum logic [0:0] {
    OP_DECOMPOSE = 1'b0,
    OP_SCALE     = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic [63:0]        value_bits;
    logic signed [31:0] scale_exp;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        result_bits;
    logic signed [11:0] exponent_out;
  } out_item_t;

  // Stage record after normalization.
  typedef struct packed {
    logic               op;
    logic               zero;
    logic               nan;
    logic               sign;
    logic [51:0]        frac;
    logic signed [11:0] bexp;
    logic signed [31:0] scale_exp;
  } norm_t;

  // Stage record after the exponent add.
  typedef struct packed {
    logic               op;
    logic               zero;
    logic               nan;
    logic               sign;
    logic [51:0]        frac;
    logic signed [11:0] bexp;
    logic signed [33:0] sum;
  } sum_t;

endpackage

FILE: hdl/float64_exponent_unit_core.sv
// Top level of the float64 exponent unit: four register stages, the last one the output register.
// Depends on f64eu_pkg and f64eu_lz.
//
// Exponent operations on raw IEEE-754 double bits. op = decompose splits the operand into a
// mantissa carrying biased exponent 1022 (sign kept) and exponent = biased exp - 1022; op = scale
// adds scale_exp to the biased exponent, flushing to +0 at or below exponent zero and
// saturating to infinity at 2047 or above (+inf only for positive non-NaN operands). Zero
// operands give +0 and exponent 0. Subnormals are normalized first. One item enters per
// cycle while the output register is empty or taken. Stages: leading one search,
// normalizing shift, 34-bit exponent add, result format. All stages advance together
// when the output register is empty or taken, so a stall holds every item in place.
module float64_exponent_unit_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  f64eu_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output f64eu_pkg::out_item_t  out_data
);
  import f64eu_pkg::*;

  logic       advance;
  logic [3:0] vld;
  logic [5:0] lz_pos;
  logic [51:0] lz_frac;

  // Stage 1 side data.
  logic        s1_op, s1_zero, s1_nan, s1_sign, s1_sub;
  logic [51:0] s1_frac;
  logic [10:0] s1_exp;
  logic signed [31:0] s1_scale;

  norm_t     s2;
  norm_t     s2_next;
  sum_t      s3;
  out_item_t res_next;

  // Advance whole pipe when the last stage can move.
  assign advance   = !vld[3] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  f64eu_lz u_lz (
    .clk      (clk),
    .advance  (advance),
    .frac     (in_data.value_bits[51:0]),
    .pos      (lz_pos),
    .norm_frac(lz_frac)
  );

  // Stage 1: capture fields and classify.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op    <= in_data.op;
      s1_sign  <= in_data.value_bits[63];
      s1_exp   <= in_data.value_bits[62:52];
      s1_frac  <= in_data.value_bits[51:0];
      s1_scale <= in_data.scale_exp;
      s1_zero  <= in_data.value_bits[62:0] == '0;
      s1_sub   <= in_data.value_bits[62:52] == '0;
      s1_nan   <= in_data.value_bits[62:52] == ExpMax && in_data.value_bits[51:0] != '0;
    end
  end

  // Stage 2: pick normalized fraction and exponent.
  always_comb begin
    s2_next.op        = s1_op;
    s2_next.zero      = s1_zero;
    s2_next.nan       = s1_nan;
    s2_next.sign      = s1_sign;
    s2_next.scale_exp = s1_scale;
    if (s1_sub) begin
      s2_next.frac = lz_frac;
      s2_next.bexp = 12'(signed'({6'b0, lz_pos})) - 12'sd51;
    end else begin
      s2_next.frac = s1_frac;
      s2_next.bexp = signed'({1'b0, s1_exp});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: exponent add without wrap.
  always_ff @(posedge clk) begin
    if (advance) begin
      s3.op   <= s2.op;
      s3.zero <= s2.zero;
      s3.nan  <= s2.nan;
      s3.sign <= s2.sign;
      s3.frac <= s2.frac;
      s3.bexp <= s2.bexp;
      s3.sum  <= 34'(s2.bexp) + 34'(s2.scale_exp);
    end
  end

  // Stage 4: format result.
  always_comb begin
    res_next = '0;
    if (!s3.zero) begin
      if (s3.op == OP_DECOMPOSE) begin
        res_next.result_bits  = {s3.sign, HalfBiased, s3.frac};
        res_next.exponent_out = s3.bexp - 12'(HalfBiased);
      end else if (s3.sum <= 0) begin
        res_next.result_bits = '0;
      end else if (s3.sum >= 34'(ExpMax)) begin
        res_next.result_bits = {(s3.sign || s3.nan), ExpMax, 52'b0};
      end else begin
        res_next.result_bits = {s3.sign, s3.sum[10:0], s3.frac};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end
endmodule

FILE: hdl/f64eu_lz.sv
// Leading-one search and normalizing shift for subnormal fractions, two stages.
// Depends on f64eu_pkg.
module f64eu_lz (
  input  logic        clk,
  input  logic        advance,
  input  logic [51:0] frac,
  output logic [5:0]  pos,
  output logic [51:0] norm_frac
);
  import f64eu_pkg::*;

  logic [5:0]  pos_c;
  logic [51:0] frac_q;
  logic [5:0]  pos_q;

  // Find highest set bit (0 when none).
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < FracBits; i++) begin
      if (frac[i]) begin
        pos_c = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frac_q <= frac;
      pos_q  <= pos_c;
    end
  end

  // Move leading one to the hidden position, drop it.
  assign norm_frac = frac_q << (6'(FracBits) - pos_q);
  assign pos = pos_q;
endmodule
